FILE: src/skvt_pkg.sv
// Shared types and constants of the sorted key/value table.
// Used by skvt_cell and sorted_key_value_table; depends on nothing.
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;

    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_LOWER  = 2'd1,
        OP_INSERT = 2'd2,
        OP_ERASE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             cmp;
        logic [KEY_W-1:0] cmp_key;
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] new_key;
        logic [KEY_W-1:0] new_value;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: src/skvt_cell.sv
// One slot of the table: a key/value pair, its valid bit and its compare flags.
// Depends on skvt_pkg.
`default_nettype none

module skvt_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire skvt_pkg::t_cell_ctl      i_ctl,
    input  wire logic                     i_prev_less,
    input  wire logic                     i_prev_valid,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_prev_key,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_prev_value,
    input  wire logic                     i_next_valid,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_next_key,
    input  wire logic [skvt_pkg::KEY_W-1:0] i_next_value,
    output logic                          o_less,
    output logic                          o_eq,
    output logic                          o_mark,
    output logic                          o_valid,
    output logic [skvt_pkg::KEY_W-1:0]    o_key,
    output logic [skvt_pkg::KEY_W-1:0]    o_value
);
    import skvt_pkg::*;

    logic             r_valid;
    logic             r_less;
    logic             r_eq;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_less  <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_less <= r_valid && ($signed(r_key) < $signed(i_ctl.cmp_key));
                r_eq   <= r_valid && (r_key == i_ctl.cmp_key);
            end
            // Cells below the insertion point keep their contents.
            if (i_ctl.ins && !r_less) begin
                r_valid <= i_prev_valid;
            end else if (i_ctl.del && !r_less) begin
                r_valid <= i_next_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_less) begin
            r_key   <= i_prev_less ? i_ctl.new_key   : i_prev_key;
            r_value <= i_prev_less ? i_ctl.new_value : i_prev_value;
        end else if (i_ctl.del && !r_less) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    // The first cell that is empty or whose key is not less than the search key.
    assign o_mark  = i_prev_less && !r_less;
    assign o_less  = r_less;
    assign o_eq    = r_eq;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

`default_nettype wire

FILE: src/sorted_key_value_table.sv
// Sorted key/value table built as a row of compare-and-shift cells.
// Words are compared in all cells on accept; inserts and erases shift cells in S_UPD, and
// the result is registered on leaving S_UPD; no word is taken in S_UPD or while it waits.
// Reset clears the entry count, the valid bits and the handshake state at once;
// stored keys and values are not cleared and there is no clearing pass.
// Depends on skvt_pkg and skvt_cell.
`default_nettype none

module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF,
    parameter int PW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((2 * PW + 65 + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [63:0]      i_s_tdata,   // key[31:0], value[63:32]
    input  wire logic [1:0]       i_s_tuser,   // mode[1:0]
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // position, at_end, key, value, occupancy
    output logic [1:0]            o_m_tuser    // status[1:0]
);
    import skvt_pkg::*;

    localparam int OUT_BITS = 2 * PW + 65;
    localparam int PAD_W    = OUT_W - OUT_BITS;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_value;
    logic [PW-1:0]    r_count;

    logic             r_out_valid;
    t_status          r_status;
    logic [PW-1:0]    r_pos;
    logic             r_at_end;
    logic [KEY_W-1:0] r_okey;
    logic [KEY_W-1:0] r_oval;
    logic [PW-1:0]    r_occ;

    logic             w_accept;
    t_cell_ctl        w_ctl;

    logic [CAPACITY-1:0] w_less;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_mark;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_prev_less;
    logic [CAPACITY-1:0] w_prev_valid;
    logic [CAPACITY-1:0] w_next_valid;
    logic [KEY_W-1:0]    w_key   [CAPACITY];
    logic [KEY_W-1:0]    w_value [CAPACITY];

    logic             w_hit;
    logic             w_full;
    logic             w_pos_valid;
    logic             w_next_ok;
    logic [PW-1:0]    w_pos;
    logic [KEY_W-1:0] w_sel_key;
    logic [KEY_W-1:0] w_sel_value;
    logic [KEY_W-1:0] w_nxt_key;
    logic [KEY_W-1:0] w_nxt_value;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_hit  = |w_eq;
    assign w_full = (r_count == PW'(CAPACITY));

    always_comb begin
        w_ctl           = '0;
        w_ctl.cmp       = w_accept;
        w_ctl.cmp_key   = i_s_tdata[31:0];
        w_ctl.new_key   = r_key;
        w_ctl.new_value = r_value;
        if (r_state == S_UPD) begin
            w_ctl.ins = (r_op == OP_INSERT) && !w_hit && !w_full;
            w_ctl.del = (r_op == OP_ERASE) && w_hit;
        end
    end

    assign w_prev_less  = {w_less[CAPACITY-2:0], 1'b1};
    assign w_prev_valid = {w_valid[CAPACITY-2:0], 1'b1};
    assign w_next_valid = {1'b0, w_valid[CAPACITY-1:1]};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_pk;
        logic [KEY_W-1:0] w_pv;
        logic [KEY_W-1:0] w_nk;
        logic [KEY_W-1:0] w_nv;

        if (g == 0) begin : g_first
            assign w_pk = '0;
            assign w_pv = '0;
        end else begin : g_mid
            assign w_pk = w_key[g-1];
            assign w_pv = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_nk = '0;
            assign w_nv = '0;
        end else begin : g_body
            assign w_nk = w_key[g+1];
            assign w_nv = w_value[g+1];
        end

        skvt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_less  (w_prev_less[g]),
            .i_prev_valid (w_prev_valid[g]),
            .i_prev_key   (w_pk),
            .i_prev_value (w_pv),
            .i_next_valid (w_next_valid[g]),
            .i_next_key   (w_nk),
            .i_next_value (w_nv),
            .o_less       (w_less[g]),
            .o_eq         (w_eq[g]),
            .o_mark       (w_mark[g]),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_value      (w_value[g])
        );
    end

    // One-hot mark to index, and the pair at the mark and just after it.
    always_comb begin
        logic [PW-1:0] v_enc;
        v_enc       = '0;
        w_sel_key   = '0;
        w_sel_value = '0;
        w_nxt_key   = '0;
        w_nxt_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_mark[i]) begin
                v_enc = v_enc | PW'(i);
                if (w_valid[i]) begin
                    w_sel_key   = w_sel_key   | w_key[i];
                    w_sel_value = w_sel_value | w_value[i];
                end
                if (i < CAPACITY - 1) begin
                    if (w_valid[(i + 1) % CAPACITY]) begin
                        w_nxt_key   = w_nxt_key   | w_key[(i + 1) % CAPACITY];
                        w_nxt_value = w_nxt_value | w_value[(i + 1) % CAPACITY];
                    end
                end
            end
        end
        // With every cell holding a smaller key, the position is the capacity.
        w_pos = (|w_mark) ? v_enc : PW'(CAPACITY);
    end

    assign w_pos_valid = |(w_mark & w_valid);
    assign w_next_ok   = |(w_mark & w_next_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_op'(i_s_tuser);
                        r_key   <= i_s_tdata[31:0];
                        r_value <= i_s_tdata[63:32];
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                    r_pos       <= w_pos;
                    r_at_end    <= !w_pos_valid;
                    r_okey      <= w_sel_key;
                    r_oval      <= w_sel_value;
                    r_occ       <= r_count;
                    r_status    <= ST_OK;
                    case (r_op)
                        OP_FIND: begin
                            if (!w_hit) begin
                                r_status <= ST_ABSENT;
                                r_pos    <= r_count;
                                r_at_end <= 1'b1;
                                r_okey   <= '0;
                                r_oval   <= '0;
                            end
                        end
                        OP_LOWER: begin
                            r_status <= ST_OK;
                        end
                        OP_INSERT: begin
                            if (w_hit) begin
                                r_status <= ST_PRESENT;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_at_end <= 1'b0;
                                r_okey   <= r_key;
                                r_oval   <= r_value;
                                r_count  <= r_count + 1'b1;
                                r_occ    <= r_count + 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (w_hit) begin
                                r_at_end <= !w_next_ok;
                                r_okey   <= w_nxt_key;
                                r_oval   <= w_nxt_value;
                                r_count  <= r_count - 1'b1;
                                r_occ    <= r_count - 1'b1;
                            end else begin
                                r_status <= ST_ABSENT;
                                r_pos    <= r_count;
                                r_at_end <= 1'b1;
                                r_okey   <= '0;
                                r_oval   <= '0;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                        end
                    endcase
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_occ, r_oval, r_okey, r_at_end, r_pos};

`ifndef NO_ASSERTIONS
    // The valid bits form a prefix; this check compares their number with the entry count.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == 32'(r_count))
        else $error("valid bits disagree with entry count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(CAPACITY))
        else $error("entry count above capacity");

    // Keys are unique, so at most one cell can match.
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_eq))
        else $error("more than one cell matches the key");

    a_result_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !r_out_valid ##1 r_out_valid)
        else $error("result word not produced two cycles after accept");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_sorted_key_value_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_value_table: random and directed table operations.
// A mirror of the sorted table predicts every reply word; depends on skvt_pkg and the RTL.

module tb_sorted_key_value_table;
    import skvt_pkg::*;

    localparam int TABLE_DEPTH  = CAPACITY_DEF;
    localparam int POS_W        = $clog2(TABLE_DEPTH + 1);
    localparam int REPLY_W      = ((2 * POS_W + 65 + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 1350;
    localparam int STALL_LIMIT  = 1000;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT      = 400;
    localparam int TAIL_CYCLES  = 16;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic              at_end;
        logic [31:0]       slot_key;
        logic [31:0]       slot_value;
        logic [POS_W-1:0]  occupancy;
    } t_reply;

    // Mirror of the sorted table; holds the replies still owed by the block.
    class kv_table_mirror;
        logic signed [31:0] keys [TABLE_DEPTH];
        logic signed [31:0] values [TABLE_DEPTH];
        int                 count;
        t_reply             awaited [$];
        int                 mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function int first_not_less(logic signed [31:0] key);
            int idx;
            idx = 0;
            while (idx < count && keys[idx] < key) idx++;
            return idx;
        endfunction

        function t_reply describe(t_status status, int pos);
            t_reply r;
            r.status     = status;
            r.position   = POS_W'(pos);
            r.at_end     = (pos >= count);
            r.slot_key   = '0;
            r.slot_value = '0;
            if (pos < count) begin
                r.slot_key   = keys[pos];
                r.slot_value = values[pos];
            end
            r.occupancy  = POS_W'(count);
            return r;
        endfunction

        function void note_request(t_op op, logic signed [31:0] key, logic signed [31:0] value);
            int pos;
            bit hit;
            pos = first_not_less(key);
            hit = (pos < count) && (keys[pos] == key);
            case (op)
                OP_FIND: begin
                    awaited.push_back(hit ? describe(ST_OK, pos) : describe(ST_ABSENT, count));
                end
                OP_LOWER: begin
                    awaited.push_back(describe(ST_OK, pos));
                end
                OP_INSERT: begin
                    if (hit) begin
                        awaited.push_back(describe(ST_PRESENT, pos));
                    end else if (count >= TABLE_DEPTH) begin
                        awaited.push_back(describe(ST_FULL, pos));
                    end else begin
                        for (int i = count; i > pos; i--) begin
                            keys[i]   = keys[i-1];
                            values[i] = values[i-1];
                        end
                        keys[pos]   = key;
                        values[pos] = value;
                        count++;
                        awaited.push_back(describe(ST_OK, pos));
                    end
                end
                default: begin
                    if (hit) begin
                        for (int i = pos; i + 1 < count; i++) begin
                            keys[i]   = keys[i+1];
                            values[i] = values[i+1];
                        end
                        count--;
                        awaited.push_back(describe(ST_OK, pos));
                    end else begin
                        awaited.push_back(describe(ST_ABSENT, count));
                    end
                end
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t ns: mismatch: %s", $realtime, msg);
        endtask

        task check_reply(logic [REPLY_W-1:0] data, logic [1:0] user);
            t_reply want;
            if (awaited.size() == 0) begin
                report($sformatf("reply word %h/%0d with nothing awaited", data, user));
                return;
            end
            want = awaited.pop_front();
            if (user !== want.status)
                report($sformatf("status %0d, expected %0d", user, want.status));
            if (data[POS_W-1:0] !== want.position)
                report($sformatf("position %0d, expected %0d", data[POS_W-1:0], want.position));
            if (data[POS_W] !== want.at_end)
                report($sformatf("at_end %b, expected %b", data[POS_W], want.at_end));
            if (data[POS_W+32:POS_W+1] !== want.slot_key)
                report($sformatf("key %h, expected %h", data[POS_W+32:POS_W+1], want.slot_key));
            if (data[POS_W+64:POS_W+33] !== want.slot_value)
                report($sformatf("value %h, expected %h",
                                 data[POS_W+64:POS_W+33], want.slot_value));
            if (data[2*POS_W+64:POS_W+65] !== want.occupancy)
                report($sformatf("occupancy %0d, expected %0d",
                                 data[2*POS_W+64:POS_W+65], want.occupancy));
        endtask
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [63:0]        s_tdata  = '0;   // key[31:0], value[63:32]
    logic [1:0]         s_tuser  = '0;   // mode[1:0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [REPLY_W-1:0] m_tdata;         // position, at_end, key, value, occupancy
    logic [1:0]         m_tuser;         // status[1:0]

    kv_table_mirror mirror;
    int             words_sent  = 0;
    int             replies_got = 0;
    int             quiet       = 0;
    bit             send_steady = 1'b0;
    bit             take_steady = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sorted_key_value_table #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    task automatic send_word(t_op op, logic signed [31:0] key, logic signed [31:0] value);
        int gap;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        mirror.note_request(op, key, value);
        words_sent++;
    endtask

    // Stops offering words until every reply owed so far has come back.
    task automatic wait_for_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.awaited.size() != 0) @(posedge clk);
    endtask

    // Mixes keys already in the table, edge keys, keys near zero and fully random keys.
    function automatic logic signed [31:0] pick_key(int present_pct);
        int r;
        r = $urandom_range(0, 99);
        if (mirror.count > 0 && r < present_pct)
            return mirror.keys[$urandom_range(0, mirror.count - 1)];
        if (r < present_pct + 15) begin
            case ($urandom_range(0, 5))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return KEY_MIN + 1;
                3:       return KEY_MAX - 1;
                default: return int'($urandom_range(0, 15)) - 8;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int   target;
        int   extra;
        int   r;
        t_op  op;
        mirror = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, edge keys, duplicates, hits at both ends and misses.
        send_word(OP_FIND,   5,        32'sh1234_5678);
        send_word(OP_LOWER,  0,        0);
        send_word(OP_ERASE,  5,        0);
        send_word(OP_INSERT, KEY_MIN,  KEY_MAX);
        send_word(OP_INSERT, KEY_MAX,  KEY_MIN);
        send_word(OP_INSERT, 0,        -1);
        send_word(OP_INSERT, -1,       32'sh5555_5555);
        send_word(OP_INSERT, 0,        123);
        send_word(OP_FIND,   KEY_MIN,  0);
        send_word(OP_FIND,   KEY_MAX,  0);
        send_word(OP_FIND,   7,        0);
        send_word(OP_LOWER,  1,        0);
        send_word(OP_LOWER,  KEY_MIN,  0);
        send_word(OP_ERASE,  KEY_MAX,  0);
        send_word(OP_LOWER,  100,      0);
        send_word(OP_ERASE,  42,       0);
        send_word(OP_ERASE,  KEY_MIN,  0);
        send_word(OP_ERASE,  -1,       0);
        send_word(OP_ERASE,  0,        0);
        send_word(OP_INSERT, 32'shAAAA_AAAA, 32'sh5555_5555);
        send_word(OP_FIND,   32'shAAAA_AAAA, 0);
        wait_for_replies();

        // Each round fills the table, sends more words while it is full, then shrinks it to three entries or fewer.
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            extra = 0;
            while (extra < 12) begin
                if (mirror.count == TABLE_DEPTH) extra++;
                r  = $urandom_range(0, 99);
                op = (r < 70) ? OP_INSERT : (r < 80) ? OP_FIND : (r < 90) ? OP_LOWER : OP_ERASE;
                send_word(op, pick_key(25), $urandom);
            end
            while (mirror.count > 3) begin
                r  = $urandom_range(0, 99);
                op = (r < 65) ? OP_ERASE : (r < 75) ? OP_INSERT : (r < 88) ? OP_FIND : OP_LOWER;
                send_word(op, pick_key(70), $urandom);
            end
            wait_for_replies();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0) begin
            $display("sorted_key_value_table verification clean");
        end else begin
            $display("sorted_key_value_table verification failed");
        end
        $finish;
    end

    // Reply side; once in the run it holds off long enough to back up the block.
    initial begin
        int gap;
        wait (rst_n);
        forever begin
            if (replies_got == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
                gap = take_steady ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            mirror.check_reply(m_tdata, m_tuser);
            replies_got++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("sorted_key_value_table verification failed");
                $finish;
            end
        end
    end

endmodule

FILE: files.f
src/skvt_pkg.sv
src/skvt_cell.sv
src/sorted_key_value_table.sv
dv/tb_sorted_key_value_table.sv
